### design/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`endif
`endif

### design/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation codes and
// controller-to-datapath command and status types. No dependencies.
`default_nettype none
package rau_pkg;
  localparam int FieldBits = 16;
  localparam int DenBits   = 2 * FieldBits;
  localparam int NumBits   = 2 * FieldBits + 1;
  localparam int MagBits   = 2 * FieldBits + 1;
  localparam int CntBits   = $clog2(MagBits + 1);
  localparam int InBytes   = (3 + 4 * FieldBits + 7) / 8;
  localparam int OutBytes  = (NumBits + DenBits + 7) / 8;

  typedef enum logic [2:0] {
    FN_MAKE = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_MUL  = 3'd3,
    FN_DIV  = 3'd4
  } func_t;

  typedef struct packed {
    logic load;      // capture the input item
    logic mul1;      // first product pair
    logic mul2;      // second product pair, form numerator and denominator
    logic gcd_init;  // start the gcd from the magnitudes
    logic div_step;  // one restoring division step
    logic div_end;   // finish one remainder: swap operands
    logic q_init;    // start dividing num and den by the gcd
    logic q_end;     // store the quotients and apply sign
  } cmd_t;

  typedef struct packed {
    logic is_err;
    logic needs_red;
    logic gcd_done;  // divisor is zero
  } stat_t;
endpackage
`default_nettype wire

### design/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand registers, one pair of
// multipliers, one shift-subtract divider for gcd and reduction. Uses rau_pkg.
`default_nettype none
`include "assert_macros.svh"
module rau_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire rau_pkg::cmd_t                      cmd,
  input  wire logic [2:0]                         in_func,
  input  wire logic signed [rau_pkg::FieldBits-1:0] in_a_num,
  input  wire logic signed [rau_pkg::FieldBits-1:0] in_a_den,
  input  wire logic signed [rau_pkg::FieldBits-1:0] in_b_num,
  input  wire logic signed [rau_pkg::FieldBits-1:0] in_b_den,
  input  wire logic                               q_phase,
  output rau_pkg::stat_t                          stat,
  output logic                                    div_last,
  output logic signed [rau_pkg::NumBits-1:0]      res_num,
  output logic signed [rau_pkg::DenBits-1:0]      res_den,
  output logic                                    res_err
);
  import rau_pkg::*;

  logic [2:0]                  func_r;
  logic signed [FieldBits-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [DenBits-1:0]   p_r, q_r;
  logic signed [NumBits-1:0]   n_r;
  logic signed [DenBits-1:0]   d_r;
  logic [MagBits-1:0]          x_r, y_r, rem_r, quo_r, g_r;
  logic [CntBits-1:0]          cnt_r;
  logic                        err_r;
  logic signed [FieldBits-1:0] m1a, m1b, m2a, m2b;
  logic signed [DenBits-1:0]   prod1, prod2;
  logic [MagBits-1:0]          dividend, rem_sh, nmag, dmag;
  logic [MagBits:0]            trial;
  logic signed [NumBits-1:0]   qn;
  logic signed [DenBits-1:0]   qd;
  logic                        ad_z, bd_z, bn_z, err_c;

  assign ad_z = (ad_r == '0);
  assign bd_z = (bd_r == '0);
  assign bn_z = (bn_r == '0);
  always_comb begin
    case (func_r)
      FN_MAKE: err_c = ad_z;
      FN_ADD, FN_SUB, FN_MUL: err_c = ad_z | bd_z;
      FN_DIV:  err_c = ad_z | bd_z | bn_z;
      default: err_c = 1'b1;
    endcase
  end
  assign stat.is_err    = err_c;
  assign stat.needs_red = (func_r == FN_MAKE) || (func_r == FN_ADD) || (func_r == FN_SUB);
  assign stat.gcd_done  = (y_r == '0);
  assign div_last       = (cnt_r == CntBits'(MagBits - 1));

  // One multiplier pair per step; operands chosen by step and function.
  always_comb begin
    m1a = an_r; m1b = bd_r; m2a = ad_r; m2b = bn_r;
    if (cmd.mul1) begin
      if (func_r == FN_MUL) m1b = bn_r;
      m2a = ad_r;
      m2b = (func_r == FN_DIV) ? bn_r : bd_r;
    end
  end
  assign prod1 = DenBits'(m1a * m1b);
  assign prod2 = DenBits'(m2a * m2b);

  assign nmag = n_r[NumBits-1] ? MagBits'(-n_r) : MagBits'(n_r);
  assign dmag = d_r[DenBits-1] ? MagBits'(-{d_r[DenBits-1], d_r}) : MagBits'({1'b0, d_r});

  assign dividend = x_r;
  assign rem_sh   = {rem_r[MagBits-2:0], dividend[CntBits'(MagBits - 1) - cnt_r]};
  assign trial    = {1'b0, rem_sh} - {1'b0, y_r};

  assign qn = NumBits'(signed'({1'b0, quo_r}));
  assign qd = DenBits'(signed'({1'b0, quo_r}));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      an_r <= in_a_num; ad_r <= in_a_den; bn_r <= in_b_num; bd_r <= in_b_den;
    end
    if (cmd.mul1) begin
      p_r <= prod1;
      q_r <= prod2;
    end
    if (cmd.mul2) begin
      err_r <= err_c;
      case (func_r)
        FN_MAKE: begin
          n_r <= NumBits'(an_r);
          d_r <= DenBits'(ad_r);
        end
        FN_ADD:  n_r <= NumBits'(p_r) + NumBits'(prod2);
        FN_SUB:  n_r <= NumBits'(p_r) - NumBits'(prod2);
        default: n_r <= NumBits'(p_r);
      endcase
      if (func_r != FN_MAKE) d_r <= q_r;
    end
    if (cmd.gcd_init) begin
      x_r <= nmag;
      y_r <= dmag;
      rem_r <= '0; quo_r <= '0; cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[MagBits]) begin
        rem_r <= trial[MagBits-1:0];
        quo_r <= {quo_r[MagBits-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[MagBits-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.div_end) begin
      // Euclid: (x, y) <- (y, x mod y)
      x_r <= y_r;
      y_r <= rem_r;
      rem_r <= '0; quo_r <= '0; cnt_r <= '0;
    end
    if (cmd.q_init) begin
      g_r <= (x_r == '0) ? MagBits'(1) : x_r;
      y_r <= (x_r == '0) ? MagBits'(1) : x_r;
      x_r <= nmag;
      rem_r <= '0; quo_r <= '0; cnt_r <= '0;
    end
    if (cmd.q_end) begin
      // First quotient pass reduces the numerator, second the denominator.
      if (!q_phase) begin
        n_r <= (n_r[NumBits-1] ^ d_r[DenBits-1]) ? -qn : qn;
        x_r <= dmag;
        y_r <= g_r;
      end else begin
        d_r <= qd;
      end
      rem_r <= '0; quo_r <= '0; cnt_r <= '0;
    end
  end

  assign res_err = err_r;
  assign res_num = err_r ? '0 : n_r;
  assign res_den = err_r ? '0 : d_r;

  `ASSERT_IMPL(a_div_cnt, clk, rst_n, cmd.div_step |-> (cnt_r < CntBits'(MagBits)), "div overrun")
  `ASSERT_IMPL(a_excl, clk, rst_n, cmd.load |-> !cmd.div_step, "load during divide")
  `ASSERT_IMPL(a_gdiv, clk, rst_n, cmd.q_init |=> (y_r != '0), "zero gcd divisor")
endmodule
`default_nettype wire

### design/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences multiply, Euclid
// and reduction steps and runs the stream handshake. Uses rau_pkg.
`default_nettype none
`include "assert_macros.svh"
module rau_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_fire,
  input  wire rau_pkg::stat_t stat,
  input  wire logic           div_last,
  output rau_pkg::cmd_t       cmd,
  output logic                q_phase,
  output logic                busy,
  output logic                out_valid
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_CHK, S_GDIV, S_GEND, S_QDIV, S_QEND, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   qph_r, qph_nxt;
  // Marks that the division in progress belongs to Euclid, not reduction.
  logic   cmd_g_r, cmd_g_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    qph_nxt = qph_r;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1; state_nxt = S_MUL1;
      end
      S_MUL1: begin cmd.mul1 = 1'b1; state_nxt = S_MUL2; end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = (stat.needs_red && !stat.is_err) ? S_CHK : S_OUT;
      end
      S_CHK: begin cmd.gcd_init = 1'b1; state_nxt = S_GEND; end
      S_GEND: begin
        if (stat.gcd_done) begin
          cmd.q_init = 1'b1; qph_nxt = 1'b0; state_nxt = S_QDIV;
        end else state_nxt = S_GDIV;
      end
      S_GDIV: begin
        cmd.div_step = 1'b1;
        if (div_last) state_nxt = S_QEND;
      end
      S_QDIV: begin
        cmd.div_step = 1'b1;
        if (div_last) state_nxt = S_QEND;
      end
      S_QEND: begin
        if (!stat.gcd_done && state_r == S_QEND && cmd_g_r) begin
          cmd.div_end = 1'b1; state_nxt = S_GEND;
        end else begin
          cmd.q_end = 1'b1;
          if (qph_r) state_nxt = S_OUT;
          else begin qph_nxt = 1'b1; state_nxt = S_QDIV; end
        end
      end
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_g_nxt = cmd_g_r;
    if (state_r == S_GDIV) cmd_g_nxt = 1'b1;
    if (state_r == S_QDIV || state_r == S_IDLE) cmd_g_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      qph_r <= 1'b0;
      cmd_g_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      qph_r <= qph_nxt;
      cmd_g_r <= (state_r == S_QEND) ? 1'b0 : cmd_g_nxt;
    end
  end

  assign q_phase = qph_r;
  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  `ASSERT_IMPL(a_in_idle, clk, rst_n, in_fire |-> (state_r == S_IDLE), "accept while busy")
  `ASSERT_IMPL(a_out_st, clk, rst_n, out_fire |=> (state_r == S_IDLE), "no return to idle")
  `ASSERT_ALWAYS(a_onecmd, clk, rst_n, $onehot0(cmd), "multiple commands")
endmodule
`default_nettype wire

### design/rational_arith_unit.sv
// Rational arithmetic unit: multiply and divide present the result after the
// multiply steps; make, add and subtract, unless in error, also run the Euclid
// steps and the quotient passes. One item at a time: the next item is accepted
// at the clock edge after the one that takes the result.
// The gcd runs on one shared shift-subtract divider, one quotient bit a cycle.
// Synchronous active-low reset returns the controller to idle, no output valid.
`default_nettype none
module rational_arith_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // func[2:0], a_num[18:3], a_den[34:19], b_num[50:35], b_den[66:51], zero fill
  input  wire logic [8*rau_pkg::InBytes-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // res_num[32:0], res_den[64:33], zero fill
  output logic [8*rau_pkg::OutBytes-1:0]       out_tdata,
  // err
  output logic                                 out_tuser
);
  import rau_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  q_phase, busy, div_last, in_fire, out_fire;
  logic signed [NumBits-1:0] res_num;
  logic signed [DenBits-1:0] res_den;

  assign in_tready = !busy;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  rau_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .stat, .div_last,
    .cmd, .q_phase, .busy, .out_valid(out_tvalid)
  );

  rau_datapath u_dp (
    .clk, .rst_n, .cmd,
    .in_func (in_tdata[2:0]),
    .in_a_num(in_tdata[3 +: FieldBits]),
    .in_a_den(in_tdata[3+FieldBits +: FieldBits]),
    .in_b_num(in_tdata[3+2*FieldBits +: FieldBits]),
    .in_b_den(in_tdata[3+3*FieldBits +: FieldBits]),
    .q_phase, .stat, .div_last, .res_num, .res_den, .res_err(out_tuser)
  );

  assign out_tdata = {{(8*OutBytes-NumBits-DenBits){1'b0}}, res_den, res_num};
endmodule
`default_nettype wire
